>>> rtl/core/dtt_pkg.sv
// Package for the deadline timer table: sizes, command and status codes,
// payload words and the control/status bundles between controller and datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dtt_pkg;

    localparam int unsigned TIMERS    = 16;
    localparam int unsigned TIME_BITS = 48;
    localparam int unsigned SLOT_BITS = $clog2(TIMERS);
    localparam int unsigned PER_BITS  = 32;
    localparam int unsigned WAIT_BITS = 32;
    localparam int unsigned ID_BITS   = 4;

    // Offset that turns a signed distance from now into an unsigned key.
    localparam logic [TIME_BITS-1:0] TSIGN = {1'b1, {(TIME_BITS-1){1'b0}}};

    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_CANCEL  = 3'd1;
    localparam logic [2:0] CMD_REFRESH = 3'd2;
    localparam logic [2:0] CMD_RESET   = 3'd3;
    localparam logic [2:0] CMD_EXPIRE  = 3'd4;
    localparam logic [2:0] CMD_QUERY   = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_INACTIVE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef logic [SLOT_BITS-1:0] t_slot;
    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic [2:0]           cmd;
        logic [TIME_BITS-1:0] now_ms;
        logic [3:0]           slot;
        logic [PER_BITS-1:0]  period_ms;
        logic                 oneshot;
        logic                 restart;
    } t_in_word;

    typedef struct packed {
        logic [1:0]           status;
        logic [ID_BITS-1:0]   slot_id;
        logic [WAIT_BITS-1:0] wait_ms;
        logic                 front_inserted;
        logic                 has_timer;
        logic                 last;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic decode;
        logic alloc;
        logic cancel;
        logic refresh;
        logic rst_start;
        logic rst_write;
        logic scan_clr;
        logic scan_step;
        logic take;
        logic emit;
        logic respond;
    } t_dp_ctl;

    typedef struct packed {
        logic [2:0] cmd;
        logic       slot_ok;
        logic       keep_same;
        logic       scan_last;
        logic       found;
        logic       list_empty;
        logic       emit_last;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/core/dtt_datapath.sv
// Datapath of the deadline timer table: the timer store, the minimum-deadline
// scan unit, the expiry list and the result register.
// Depends on dtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtt_datapath import dtt_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_in_word  i_item,
    input  wire t_dp_ctl   i_ctl,
    output t_dp_stat       o_stat,
    output logic           o_result_valid,
    output t_out_word      o_result
);

    // Timer store.
    logic                r_valid [TIMERS];
    logic                r_taken [TIMERS];
    logic                r_oneshot [TIMERS];
    logic [PER_BITS-1:0] r_period [TIMERS];
    t_time               r_deadline [TIMERS];
    t_slot               r_list [TIMERS];

    t_in_word            r_item, n_item;
    t_slot               r_idx, n_idx;
    t_slot               r_best, n_best;
    t_time               r_best_key, n_best_key;
    logic                r_found, n_found;
    t_slot               r_target, n_target;
    logic [1:0]          r_status, n_status;
    t_time               r_tmp, n_tmp;
    logic [SLOT_BITS:0]  r_count, n_count;
    t_slot               r_emit, n_emit;
    logic                r_out_valid, n_out_valid;
    t_out_word           r_out, n_out;

    t_slot               rd_idx;
    t_time               rd_deadline;
    logic [PER_BITS-1:0] rd_period;
    logic                rd_oneshot;
    t_time               key_now;
    logic                eligible;
    logic                free_any;
    t_slot               free_idx;
    logic                slot_hit;
    logic                any_valid;
    logic                late;
    logic [WAIT_BITS-1:0] wait_val;

    logic                wr_dl_en;
    t_time               wr_dl_data;
    logic                wr_per_en;
    logic                wr_one_en;

    assign rd_idx      = i_ctl.scan_step ? r_idx : (i_ctl.take ? r_best : r_target);
    assign rd_deadline = r_deadline[rd_idx];
    assign rd_period   = r_period[rd_idx];
    assign rd_oneshot  = r_oneshot[rd_idx];

    // Signed distance of the deadline from now, offset so that it sorts unsigned.
    assign key_now  = (rd_deadline - r_item.now_ms) ^ TSIGN;
    assign eligible = r_valid[r_idx] && !r_taken[r_idx]
                      && ((r_item.cmd != CMD_EXPIRE) || (key_now <= TSIGN));

    always_comb begin
        free_any  = 1'b0;
        free_idx  = '0;
        any_valid = 1'b0;
        for (int i = TIMERS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_BITS'(i);
            end
            if (r_valid[i]) begin
                any_valid = 1'b1;
            end
        end
    end

    assign slot_hit = (32'(r_item.slot) < TIMERS) && r_valid[r_item.slot[SLOT_BITS-1:0]];

    // A deadline still ahead of now gives a positive wait, which saturates.
    assign late = r_best_key[TIME_BITS-1] && (|r_best_key[TIME_BITS-2:0]);
    always_comb begin
        if (!late) begin
            wait_val = '0;
        end else if (|r_best_key[TIME_BITS-2:WAIT_BITS]) begin
            wait_val = '1;
        end else begin
            wait_val = r_best_key[WAIT_BITS-1:0];
        end
    end

    always_comb begin
        o_stat.cmd        = r_item.cmd;
        o_stat.slot_ok    = (r_item.cmd == CMD_ADD) ? free_any : slot_hit;
        o_stat.keep_same  = (rd_period == r_item.period_ms) && !r_item.restart;
        o_stat.scan_last  = (r_idx == SLOT_BITS'(TIMERS - 1));
        o_stat.found      = r_found || eligible;
        o_stat.list_empty = (r_count == '0);
        o_stat.emit_last  = (r_count == ({1'b0, r_emit} + (SLOT_BITS+1)'(1)));
    end

    // Store write controls.
    always_comb begin
        wr_dl_en   = 1'b0;
        wr_dl_data = r_item.now_ms + TIME_BITS'(r_item.period_ms);
        wr_per_en  = i_ctl.alloc || i_ctl.rst_write;
        wr_one_en  = i_ctl.alloc;
        if (i_ctl.alloc) begin
            wr_dl_en = 1'b1;
        end else if (i_ctl.refresh) begin
            wr_dl_en   = 1'b1;
            wr_dl_data = r_item.now_ms + TIME_BITS'(rd_period);
        end else if (i_ctl.rst_write) begin
            wr_dl_en   = 1'b1;
            wr_dl_data = r_tmp + TIME_BITS'(r_item.period_ms);
        end else if (i_ctl.take && !rd_oneshot) begin
            wr_dl_en   = 1'b1;
            wr_dl_data = r_item.now_ms + TIME_BITS'(rd_period);
        end
    end

    always_comb begin
        n_item      = r_item;
        n_idx       = r_idx;
        n_best      = r_best;
        n_best_key  = r_best_key;
        n_found     = r_found;
        n_target    = r_target;
        n_status    = r_status;
        n_tmp       = r_tmp;
        n_count     = r_count;
        n_emit      = r_emit;
        n_out_valid = i_ctl.emit || i_ctl.respond;
        n_out       = r_out;

        if (i_ctl.load) begin
            n_item = i_item;
        end

        if (i_ctl.decode) begin
            n_found  = 1'b0;
            n_count  = '0;
            n_emit   = '0;
            n_target = (r_item.cmd == CMD_ADD) ? free_idx : r_item.slot[SLOT_BITS-1:0];
            case (r_item.cmd)
                CMD_ADD:     n_status = free_any ? ST_OK : ST_FULL;
                CMD_CANCEL,
                CMD_REFRESH,
                CMD_RESET:   n_status = slot_hit ? ST_OK : ST_INACTIVE;
                CMD_EXPIRE:  n_status = ST_EMPTY;
                CMD_QUERY:   n_status = ST_OK;
                default:     n_status = ST_EMPTY;
            endcase
        end

        if (i_ctl.rst_start) begin
            n_tmp = r_item.restart ? r_item.now_ms : rd_deadline - TIME_BITS'(rd_period);
        end

        if (i_ctl.scan_clr) begin
            n_idx   = '0;
            n_found = 1'b0;
        end

        if (i_ctl.scan_step) begin
            n_idx = r_idx + SLOT_BITS'(1);
            // Ascending scan with a strict compare keeps ties on the lower slot.
            if (eligible && (!r_found || key_now < r_best_key)) begin
                n_best     = r_idx;
                n_best_key = key_now;
                n_found    = 1'b1;
            end
        end

        if (i_ctl.take) begin
            n_count = r_count + (SLOT_BITS+1)'(1);
        end

        if (i_ctl.emit) begin
            n_emit               = r_emit + SLOT_BITS'(1);
            n_out.status         = ST_OK;
            n_out.slot_id        = ID_BITS'(r_list[r_emit]);
            n_out.wait_ms        = '0;
            n_out.front_inserted = 1'b0;
            n_out.has_timer      = any_valid;
            n_out.last           = o_stat.emit_last;
        end

        if (i_ctl.respond) begin
            n_out.status  = ((r_item.cmd == CMD_QUERY) && !r_found) ? ST_EMPTY : r_status;
            n_out.slot_id = ((r_item.cmd == CMD_ADD) && (r_status == ST_OK))
                            ? ID_BITS'(r_target) : '0;
            n_out.wait_ms = ((r_item.cmd == CMD_QUERY) && r_found) ? wait_val : '0;
            n_out.front_inserted = ((r_item.cmd == CMD_ADD) || (r_item.cmd == CMD_RESET))
                                   && r_found && (r_best == r_target);
            n_out.has_timer = any_valid;
            n_out.last      = 1'b1;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TIMERS; i++) begin
                r_valid[i] <= 1'b0;
                r_taken[i] <= 1'b0;
            end
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_count     <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_idx       <= n_idx;
            r_found     <= n_found;
            r_count     <= n_count;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
            if (i_ctl.decode) begin
                for (int i = 0; i < TIMERS; i++) begin
                    r_taken[i] <= 1'b0;
                end
            end
            if (i_ctl.alloc) begin
                r_valid[r_target] <= 1'b1;
            end
            if (i_ctl.cancel) begin
                r_valid[r_target] <= 1'b0;
            end
            if (i_ctl.take) begin
                r_taken[r_best] <= 1'b1;
                if (rd_oneshot) begin
                    r_valid[r_best] <= 1'b0;
                end
            end
        end
    end

    // Payload state.
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_best     <= n_best;
        r_best_key <= n_best_key;
        r_target   <= n_target;
        r_status   <= n_status;
        r_tmp      <= n_tmp;
        r_out      <= n_out;
        if (wr_dl_en) begin
            r_deadline[rd_idx] <= wr_dl_data;
        end
        if (wr_per_en) begin
            r_period[rd_idx] <= r_item.period_ms;
        end
        if (wr_one_en) begin
            r_oneshot[rd_idx] <= r_item.oneshot;
        end
        if (i_ctl.take) begin
            r_list[r_count[SLOT_BITS-1:0]] <= r_best;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

endmodule

`default_nettype wire

>>> rtl/core/dtt_ctrl.sv
// Controller of the deadline timer table: sequences each command through the
// datapath by issuing one control bundle a cycle.
// Depends on dtt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dtt_ctrl import dtt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output logic          o_busy,
    output t_dp_ctl       o_ctl
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_ALLOC   = 4'd2;
    localparam logic [3:0] S_CANCEL  = 4'd3;
    localparam logic [3:0] S_REFRESH = 4'd4;
    localparam logic [3:0] S_RST_A   = 4'd5;
    localparam logic [3:0] S_RST_B   = 4'd6;
    localparam logic [3:0] S_SCAN    = 4'd7;
    localparam logic [3:0] S_TAKE    = 4'd8;
    localparam logic [3:0] S_EMIT    = 4'd9;
    localparam logic [3:0] S_RESP    = 4'd10;

    logic [3:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                o_ctl.decode = 1'b1;
                case (i_stat.cmd)
                    CMD_ADD:     n_state = i_stat.slot_ok ? S_ALLOC : S_RESP;
                    CMD_CANCEL:  n_state = i_stat.slot_ok ? S_CANCEL : S_RESP;
                    CMD_REFRESH: n_state = i_stat.slot_ok ? S_REFRESH : S_RESP;
                    CMD_RESET:   n_state = i_stat.slot_ok ? S_RST_A : S_RESP;
                    CMD_EXPIRE,
                    CMD_QUERY: begin
                        o_ctl.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end
                    default:     n_state = S_RESP;
                endcase
            end
            S_ALLOC: begin
                o_ctl.alloc    = 1'b1;
                o_ctl.scan_clr = 1'b1;
                n_state        = S_SCAN;
            end
            S_CANCEL: begin
                o_ctl.cancel = 1'b1;
                n_state      = S_RESP;
            end
            S_REFRESH: begin
                o_ctl.refresh = 1'b1;
                n_state       = S_RESP;
            end
            S_RST_A: begin
                // An unchanged period counted from the old start is left alone.
                if (i_stat.keep_same) begin
                    n_state = S_RESP;
                end else begin
                    o_ctl.rst_start = 1'b1;
                    n_state         = S_RST_B;
                end
            end
            S_RST_B: begin
                o_ctl.rst_write = 1'b1;
                o_ctl.scan_clr  = 1'b1;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_stat.scan_last) begin
                    if (i_stat.cmd == CMD_EXPIRE) begin
                        if (i_stat.found) begin
                            n_state = S_TAKE;
                        end else if (i_stat.list_empty) begin
                            n_state = S_RESP;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end else begin
                        n_state = S_RESP;
                    end
                end
            end
            S_TAKE: begin
                o_ctl.take     = 1'b1;
                o_ctl.scan_clr = 1'b1;
                n_state        = S_SCAN;
            end
            S_EMIT: begin
                o_ctl.emit = 1'b1;
                if (i_stat.emit_last) begin
                    n_state = S_IDLE;
                end
            end
            S_RESP: begin
                o_ctl.respond = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/core/deadline_timer_table_core.sv
// Top level of the deadline timer table: a controller and a datapath.
// Depends on dtt_pkg, dtt_ctrl and dtt_datapath.
//
// A command word is taken when start is high and busy is low; its results
// leave one a cycle on o_result, each marked by o_result_valid for exactly one
// cycle, and the receiver has no way to hold them back. The datapath finds the
// earliest deadline with a scan that visits one slot a cycle over all TIMERS
// slots. Add, reset and query run a scan; cancel, refresh, a reset that
// changes nothing and failed commands do not. Expire runs a scan and an update
// step for every due timer and one final scan, then emits its words back to
// back, or gives a single empty response when nothing is due. There is no
// clearing pass after reset; the block takes a command in the first cycle.
`timescale 1ns / 1ps
`default_nettype none

module deadline_timer_table_core import dtt_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_in_word i_item,
    output logic          o_result_valid,
    output t_out_word     o_result
);

    t_dp_ctl  ctl;
    t_dp_stat stat;

    dtt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_ctl   (ctl)
    );

    dtt_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_ctl          (ctl),
        .o_stat         (stat),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

`default_nettype wire
